[rtl/pps_pkg.sv]
`default_nettype none

package pps_pkg;

    // Field widths of one process and one run segment
    localparam int ARR_W     = 16;
    localparam int BURST_W   = 12;
    localparam int PRIO_W    = 8;
    localparam int PIDX_W    = 5;
    localparam int START_W   = 17;

    // Internal tick counter: latest arrival plus 32 full bursts still fits
    localparam int TIME_W    = 18;

    localparam int IN_FIELDS_W  = ARR_W + BURST_W + PRIO_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = PIDX_W + START_W + BURST_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // One process table entry
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    // One run segment
    typedef struct packed {
        logic [PIDX_W-1:0]  process_index;
        logic [START_W-1:0] start_time;
        logic [BURST_W-1:0] run_length;
        logic               completes;
        logic               last_segment;
    } seg_t;

endpackage

`default_nettype wire

[rtl/pps_mem.sv]
`default_nettype none

module pps_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire pps_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output pps_pkg::entry_t      rd_data
);
    import pps_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/preemptive_priority_scheduler_top.sv]
// Loading: one process per cycle, accepted back to back while the block is loading.
// Scheduling after the tlast transfer: each decision pass reads the whole process
// table through the single read port, then decides, and writes back a preempted
// burst when one was cut; at most 2N-1 segments plus idle time jumps.
// Reset (rst_n low, async) clears control, masks and counters; the process table
// itself is not cleared and holds nothing valid until loaded.
`default_nettype none

module preemptive_priority_scheduler_top #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // process load stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] arrival, [27:16] burst, [35:28] priority_level, rest zero
    input  wire logic [pps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tlast,   // last_process
    // segment stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [4:0] process_index, [21:5] start_time, [33:22] run_length, [34] completes
    output logic [pps_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tlast    // last_segment
);
    import pps_pkg::*;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    // ST_LOAD   : taking processes into the table
    // ST_SCAN   : one pass over the table: admit arrivals, pick best, find next arrival
    // ST_DECIDE : turn the pass result into a segment or a time jump
    // ST_WRBACK : store the reduced burst of a preempted process
    // ST_FLUSH  : release the held segment as the final one, clear for the next set
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_WRBACK,
        ST_FLUSH
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [MAX_PROCS-1:0] admitted_reg;
    logic [MAX_PROCS-1:0] finished_reg;
    logic [TIME_W-1:0]    time_reg;

    // scan pass
    logic [CNT_W-1:0]     iss_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 have_best_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [ARR_W-1:0]     best_arr_reg;
    logic [BURST_W-1:0]   best_rem_reg;
    logic [PRIO_W-1:0]    best_prio_reg;
    logic                 have_nxt_reg;
    logic [ARR_W-1:0]     nxt_reg;

    // one segment is held back so the final one can be flagged
    seg_t                 hold_reg;
    logic                 hold_vld_reg;
    seg_t                 out_reg;
    logic                 out_vld_reg;

    // table port
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    entry_t               rd_data;
    entry_t               in_entry;

    logic                 in_acc;
    logic                 store_ok;

    // per-entry scan terms
    logic                 adm_cur;
    logic                 fin_cur;
    logic                 arrive;
    logic                 adm_new;
    logic                 fin_new;
    logic                 ready_new;
    logic                 better;
    logic                 earlier;

    // decision terms
    logic [TIME_W-1:0]    end_time;
    logic [TIME_W-1:0]    gap;
    logic                 fits;
    logic                 can_push;
    seg_t                 new_seg;
    logic                 push_out;
    seg_t                 push_data;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign store_ok      = (cnt_reg < CNT_W'(MAX_PROCS));

    assign in_entry.arrival = s_axis_tdata[ARR_W-1:0];
    assign in_entry.burst   = s_axis_tdata[ARR_W+BURST_W-1:ARR_W];
    assign in_entry.prio    = s_axis_tdata[IN_FIELDS_W-1:ARR_W+BURST_W];

    // Write port: loading, or writeback of a preempted burst
    always_comb
    begin
        wr_en   = (in_acc && store_ok) || (state_reg == ST_WRBACK);
        wr_addr = cnt_reg[IDX_W-1:0];
        wr_data = in_entry;
        if (state_reg == ST_WRBACK)
        begin
            wr_addr         = best_idx_reg;
            wr_data.arrival = best_arr_reg;
            wr_data.burst   = best_rem_reg;
            wr_data.prio    = best_prio_reg;
        end
    end

    assign rd_en   = (state_reg == ST_SCAN) && (iss_reg < cnt_reg);
    assign rd_addr = iss_reg[IDX_W-1:0];

    pps_mem #(
        .DEPTH (MAX_PROCS),
        .AW    (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Entry returning from the table: admit if arrived, zero burst finishes at once.
    // Ties in (priority, remaining) keep the lower index since entries come in order.
    always_comb
    begin
        adm_cur   = admitted_reg[rd_idx_reg];
        fin_cur   = finished_reg[rd_idx_reg];
        arrive    = !adm_cur && (TIME_W'(rd_data.arrival) <= time_reg);
        adm_new   = adm_cur || arrive;
        fin_new   = fin_cur || (arrive && (rd_data.burst == '0));
        ready_new = adm_new && !fin_new;
        better    = ready_new
                    && (!have_best_reg
                        || (rd_data.prio < best_prio_reg)
                        || ((rd_data.prio == best_prio_reg)
                            && (rd_data.burst < best_rem_reg)));
        earlier   = !adm_new && (!have_nxt_reg || (rd_data.arrival < nxt_reg));
    end

    // Run the chosen process to completion unless a pending arrival cuts in first
    always_comb
    begin
        end_time = time_reg + TIME_W'(best_rem_reg);
        gap      = TIME_W'(nxt_reg) - time_reg;
        fits     = !have_nxt_reg || (end_time <= TIME_W'(nxt_reg));
        can_push = !out_vld_reg || m_axis_tready;

        new_seg.process_index = PIDX_W'(best_idx_reg);
        new_seg.start_time    = time_reg[START_W-1:0];
        new_seg.run_length    = fits ? best_rem_reg : gap[BURST_W-1:0];
        new_seg.completes     = fits;
        new_seg.last_segment  = 1'b0;

        push_out  = hold_vld_reg && can_push
                    && (((state_reg == ST_DECIDE) && have_best_reg)
                        || (state_reg == ST_FLUSH));
        push_data = hold_reg;
        if (state_reg == ST_FLUSH)
        begin
            push_data.last_segment = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            admitted_reg  <= '0;
            finished_reg  <= '0;
            time_reg      <= '0;
            iss_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            have_best_reg <= 1'b0;
            best_idx_reg  <= '0;
            best_arr_reg  <= '0;
            best_rem_reg  <= '0;
            best_prio_reg <= '0;
            have_nxt_reg  <= 1'b0;
            nxt_reg       <= '0;
            hold_reg      <= '0;
            hold_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // Output register: parts the scheduler from the downstream handshake
            if (push_out)
            begin
                out_vld_reg <= 1'b1;
                out_reg     <= push_data;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (store_ok)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        if (s_axis_tlast)
                        begin
                            time_reg      <= '0;
                            iss_reg       <= '0;
                            rd_vld_reg    <= 1'b0;
                            have_best_reg <= 1'b0;
                            have_nxt_reg  <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    rd_vld_reg <= rd_en;
                    rd_idx_reg <= iss_reg[IDX_W-1:0];
                    if (rd_en)
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    if (rd_vld_reg)
                    begin
                        admitted_reg[rd_idx_reg] <= adm_new;
                        finished_reg[rd_idx_reg] <= fin_new;
                        if (better)
                        begin
                            have_best_reg <= 1'b1;
                            best_idx_reg  <= rd_idx_reg;
                            best_arr_reg  <= rd_data.arrival;
                            best_rem_reg  <= rd_data.burst;
                            best_prio_reg <= rd_data.prio;
                        end
                        if (earlier)
                        begin
                            have_nxt_reg <= 1'b1;
                            nxt_reg      <= rd_data.arrival;
                        end
                    end
                    else if (!rd_en)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end

                ST_DECIDE:
                begin
                    if (!have_best_reg)
                    begin
                        // idle: jump to the next arrival, or the set is done
                        if (!have_nxt_reg)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            time_reg      <= TIME_W'(nxt_reg);
                            iss_reg       <= '0;
                            rd_vld_reg    <= 1'b0;
                            have_best_reg <= 1'b0;
                            have_nxt_reg  <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end
                    end
                    else if (!hold_vld_reg || can_push)
                    begin
                        hold_reg     <= new_seg;
                        hold_vld_reg <= 1'b1;
                        if (fits)
                        begin
                            time_reg                   <= end_time;
                            finished_reg[best_idx_reg] <= 1'b1;
                            iss_reg                    <= '0;
                            rd_vld_reg                 <= 1'b0;
                            have_best_reg              <= 1'b0;
                            have_nxt_reg               <= 1'b0;
                            state_reg                  <= ST_SCAN;
                        end
                        else
                        begin
                            best_rem_reg <= best_rem_reg - gap[BURST_W-1:0];
                            time_reg     <= TIME_W'(nxt_reg);
                            state_reg    <= ST_WRBACK;
                        end
                    end
                end

                ST_WRBACK:
                begin
                    iss_reg       <= '0;
                    rd_vld_reg    <= 1'b0;
                    have_best_reg <= 1'b0;
                    have_nxt_reg  <= 1'b0;
                    state_reg     <= ST_SCAN;
                end

                ST_FLUSH:
                begin
                    if (!hold_vld_reg || can_push)
                    begin
                        hold_vld_reg <= 1'b0;
                        cnt_reg      <= '0;
                        admitted_reg <= '0;
                        finished_reg <= '0;
                        time_reg     <= '0;
                        state_reg    <= ST_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_reg.last_segment;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                            out_reg.completes,
                            out_reg.run_length,
                            out_reg.start_time,
                            out_reg.process_index};

    // A segment always lasts at least one tick
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[33:22] != '0))
        else $error("segment with zero run length");

    // A process can only finish after it has been admitted
    a_fin_admitted: assert property (@(posedge clk) disable iff (!rst_n)
        (finished_reg & ~admitted_reg) == '0)
        else $error("finished process never admitted");

    // The loaded count never exceeds the table depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PROCS))
        else $error("loaded count beyond table depth");

    // A held segment is never overwritten while the output register is still occupied
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && have_best_reg && hold_vld_reg
         && out_vld_reg && !m_axis_tready)
        |=> (state_reg == ST_DECIDE))
        else $error("segment dropped on full output");

endmodule

`default_nettype wire

[bench/preemptive_priority_scheduler_top_test.sv]
`timescale 1ns / 1ps

module preemptive_priority_scheduler_top_test;
    import pps_pkg::*;

    localparam int PROC_SLOTS   = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    // one schedule of 16 processes: ~3N decision passes, each over the whole table
    localparam int DRAIN_CYCLES = 3000;
    localparam int ITEM_TARGET  = 410;

    // Expected segment stream, built from the loaded process table on each
    // tlast transfer.  Segments are compared in order, field by field.
    class sched_scoreboard;
        bit [ARR_W-1:0]   arr_tab [PROC_SLOTS];
        bit [BURST_W-1:0] rem_tab [PROC_SLOTS];
        bit [PRIO_W-1:0]  pri_tab [PROC_SLOTS];
        int unsigned      loaded;
        seg_t             segs_due[$];
        int unsigned      failures;

        // Earliest arrival among processes not yet admitted
        function bit earliest_pending(input bit [PROC_SLOTS-1:0] admitted,
                                      output int unsigned when);
            bit found;
            found = 1'b0;
            when  = 0;
            for (int i = 0; i < loaded; i++) begin
                if (!admitted[i] && (!found || arr_tab[i] < when)) begin
                    when  = arr_tab[i];
                    found = 1'b1;
                end
            end
            return found;
        endfunction

        function void build_schedule();
            bit [PROC_SLOTS-1:0] everyone, admitted, finished, ready;
            int unsigned         now, nxt, best, run;
            bit                  have, done;
            seg_t                seg;
            seg_t                batch[$];
            everyone = '0;
            for (int i = 0; i < loaded; i++)
                everyone[i] = 1'b1;
            admitted = '0;
            finished = '0;
            now      = 0;
            while (finished != everyone) begin
                ready = admitted & ~finished;
                if (ready == '0) begin
                    if (!earliest_pending(admitted, nxt))
                        break;
                    now = nxt;
                end
                // admit arrivals; a zero burst finishes on admission
                for (int i = 0; i < loaded; i++) begin
                    if (!admitted[i] && arr_tab[i] <= now) begin
                        admitted[i] = 1'b1;
                        if (rem_tab[i] == '0)
                            finished[i] = 1'b1;
                    end
                end
                ready = admitted & ~finished;
                if (ready == '0)
                    continue;
                // least (priority, remaining, index)
                have = 1'b0;
                best = 0;
                for (int i = 0; i < loaded; i++) begin
                    if (ready[i] && (!have || pri_tab[i] < pri_tab[best] ||
                        (pri_tab[i] == pri_tab[best] && rem_tab[i] < rem_tab[best]))) begin
                        best = i;
                        have = 1'b1;
                    end
                end
                // run to completion or up to the next arrival
                if (!earliest_pending(admitted, nxt) || now + rem_tab[best] <= nxt) begin
                    run  = rem_tab[best];
                    done = 1'b1;
                end
                else begin
                    run  = nxt - now;
                    done = 1'b0;
                end
                seg.process_index = PIDX_W'(best);
                seg.start_time    = START_W'(now);
                seg.run_length    = BURST_W'(run);
                seg.completes     = done;
                seg.last_segment  = 1'b0;
                batch = {batch, seg};
                now           += run;
                rem_tab[best] -= BURST_W'(run);
                if (done)
                    finished[best] = 1'b1;
            end
            if (batch.size() > 0)
                batch[batch.size()-1].last_segment = 1'b1;
            foreach (batch[k])
                segs_due = {segs_due, batch[k]};
        endfunction

        // Called on every accepted process transfer
        function void note_process(input bit [ARR_W-1:0] arr, input bit [BURST_W-1:0] bst,
                                   input bit [PRIO_W-1:0] pri, input bit lst);
            if (loaded < PROC_SLOTS) begin
                arr_tab[loaded] = arr;
                rem_tab[loaded] = bst;
                pri_tab[loaded] = pri;
                loaded++;
            end
            if (lst) begin
                build_schedule();
                loaded = 0;
            end
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        // Called on every accepted segment transfer
        function void check_segment(input logic [OUT_DATA_W-1:0] word, input logic tl);
            seg_t want;
            if (segs_due.size() == 0) begin
                $error("segment with none expected: tdata %h tlast %b", word, tl);
                failures++;
                return;
            end
            want = segs_due.pop_front();
            compare_field("process_index", want.process_index, word[PIDX_W-1:0]);
            compare_field("start_time", want.start_time, word[PIDX_W +: START_W]);
            compare_field("run_length", want.run_length, word[PIDX_W+START_W +: BURST_W]);
            compare_field("completes", want.completes, word[PIDX_W+START_W+BURST_W]);
            compare_field("last_segment", want.last_segment, tl);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [15:0] arrival, [27:16] burst, [35:28] priority
    logic                  s_axis_tlast;   // last_process
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [4:0] index, [21:5] start, [33:22] length, [34] completes
    logic                  m_axis_tlast;   // last_segment

    sched_scoreboard sb = new;

    // idle rates in percent, changed only between process sets
    int unsigned send_gap_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned stored_items   = 0;
    int unsigned cycle_count    = 0;

    preemptive_priority_scheduler_top #(
        .MAX_PROCS(PROC_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Segment sink: random back-pressure, every transfer goes to the scoreboard.
    // Values are read at the edge before any NBA of that edge lands.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_segment(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // One process transfer, with random idle cycles ahead of it.  tvalid stays
    // high from one transfer to the next when no gap is drawn.
    task automatic send_process(input bit [ARR_W-1:0] arr, input bit [BURST_W-1:0] bst,
                                input bit [PRIO_W-1:0] pri, input bit lst);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({pri, bst, arr});
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_process(arr, bst, pri, lst);
    endtask

    // A random process set; mostly small, often dense so that preemption and
    // ties are frequent, sometimes sparse, wide or longer than the table.
    task automatic random_set();
        int unsigned size, arr_span, burst_cap, prio_cap, pick;
        bit [BURST_W-1:0] bst;
        pick = $urandom_range(99);
        if (pick < 70)
            size = $urandom_range(6, 1);
        else if (pick < 92)
            size = $urandom_range(PROC_SLOTS, 7);
        else
            size = $urandom_range(PROC_SLOTS + 4, PROC_SLOTS + 1);
        pick      = $urandom_range(99);
        arr_span  = (pick < 40) ? 15 : (pick < 80) ? 300 : 65535;
        burst_cap = ($urandom_range(99) < 60) ? 24 : 4095;
        prio_cap  = ($urandom_range(99) < 50) ? 3 : 255;
        for (int k = 0; k < size; k++) begin
            // zero bursts are rare: admitted and finished with no segment
            bst = ($urandom_range(99) < 4) ? '0 : BURST_W'($urandom_range(burst_cap, 1));
            send_process(ARR_W'($urandom_range(arr_span)), bst,
                         PRIO_W'($urandom_range(prio_cap)), k == size - 1);
            if (k < PROC_SLOTS)
                stored_items++;
        end
    endtask

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("preemptive_priority_scheduler_top_test NOT OK");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone process at the field extremes, starts after an idle jump
        send_process(16'hFFFF, 12'hFFF, 8'hFF, 1'b1);
        // preemption, equal priority broken by remaining burst, idle gap
        send_process(16'd0, 12'd10, 8'd5, 1'b0);
        send_process(16'd3, 12'd4, 8'd1, 1'b0);
        send_process(16'd3, 12'd2, 8'd1, 1'b0);
        send_process(16'd40, 12'd1, 8'd0, 1'b1);
        // zero burst next to a normal process
        send_process(16'd0, 12'd0, 8'd0, 1'b0);
        send_process(16'd2, 12'd3, 8'd7, 1'b1);
        // a set with nothing to run: no segment at all
        send_process(16'd5, 12'd0, 8'd1, 1'b1);
        // table overflow: the 17th transfer is dropped but still starts the schedule
        for (int k = 0; k <= PROC_SLOTS; k++)
            send_process(ARR_W'(k * 3), BURST_W'(k + 1), PRIO_W'(PROC_SLOTS - k),
                         k == PROC_SLOTS);
        stored_items = 8 + PROC_SLOTS;

        // random sets across four idle profiles
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_gap_pct = 49; sink_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  sink_stall_pct = 49; end
                default: begin send_gap_pct = 34; sink_stall_pct = 34; end
            endcase
            while (stored_items < 24 + (ITEM_TARGET - 24) * (phase + 1) / 4)
                random_set();
        end
        s_axis_tvalid <= 1'b0;

        // drain: all segments in, then let a trailing empty schedule settle
        while (sb.segs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0)
            $display("preemptive_priority_scheduler_top_test OK");
        else
            $display("preemptive_priority_scheduler_top_test NOT OK");
        $finish;
    end

endmodule

[preemptive_priority_scheduler_top.f]
rtl/pps_pkg.sv
rtl/pps_mem.sv
rtl/preemptive_priority_scheduler_top.sv
bench/preemptive_priority_scheduler_top_test.sv
